### hdl/rpms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpms_pkg
// Shared types, codes and reset values of the relay power move sequencer.
// ----------------------------------------------------------------------------
package rpms_pkg;

  // Fixed field widths
  localparam int CfgW    = 24;
  localparam int PhaseW  = 3;
  localparam int OpW     = 3;
  localparam int NumCfg  = 7;
  localparam int CfgIdxW = 3;

  // Defaults for the top level parameters
  localparam int DefActuatorCount = 2;
  localparam int DefTimeBits      = 24;

  // Event codes
  localparam logic [OpW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpW-1:0] OP_START  = 3'd1;
  localparam logic [OpW-1:0] OP_STOP   = 3'd2;
  localparam logic [OpW-1:0] OP_EXTEND = 3'd3;
  localparam logic [OpW-1:0] OP_REDUCE = 3'd4;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
  localparam logic [PhaseW-1:0] PH_PRE    = 3'd1;
  localparam logic [PhaseW-1:0] PH_MAIN   = 3'd2;
  localparam logic [PhaseW-1:0] PH_PULSE  = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAUSE  = 3'd4;
  localparam logic [PhaseW-1:0] PH_SPIN   = 3'd5;
  localparam logic [PhaseW-1:0] PH_PREOFF = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PRECHARGE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAIN_SETTLE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PULSE       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POST_PAUSE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPINDOWN    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INCREMENT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_MOVE    = 3'd6;

  // Register reset values
  localparam logic [CfgW-1:0] RST_PRECHARGE   = 24'd500;
  localparam logic [CfgW-1:0] RST_MAIN_SETTLE = 24'd500;
  localparam logic [CfgW-1:0] RST_PULSE       = 24'd30000;
  localparam logic [CfgW-1:0] RST_POST_PAUSE  = 24'd500;
  localparam logic [CfgW-1:0] RST_SPINDOWN    = 24'd500;
  localparam logic [CfgW-1:0] RST_INCREMENT   = 24'd30000;
  localparam logic [CfgW-1:0] RST_MAX_MOVE    = 24'd300000;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic           actuator_index;
    logic           direction;
  } rpms_in_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              busy_res;
    logic              pre_relay_on;
    logic              main_relay_on;
    logic              actuator_on;
    logic              active_actuator;
    logic              active_direction;
    logic [CfgW-1:0]   remaining_ms;
  } rpms_out_t;

  typedef struct packed {
    logic [CfgW-1:0] pre_on_ms;
    logic [CfgW-1:0] main_settle_ms;
    logic [CfgW-1:0] drive_ms;
    logic [CfgW-1:0] post_pause_ms;
    logic [CfgW-1:0] spindown_ms;
    logic [CfgW-1:0] increment_ms;
    logic [CfgW-1:0] drive_limit_ms;
  } rpms_cfg_t;

endpackage

### hdl/rpms_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpms_cfg_regs
// Timing configuration registers, write only.
// ----------------------------------------------------------------------------
module rpms_cfg_regs
  import rpms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output rpms_cfg_t          cfg_o
);

  rpms_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRECHARGE:   cfg_d.pre_on_ms      = cfg_data_i;
        REG_MAIN_SETTLE: cfg_d.main_settle_ms = cfg_data_i;
        REG_PULSE:       cfg_d.drive_ms       = cfg_data_i;
        REG_POST_PAUSE:  cfg_d.post_pause_ms  = cfg_data_i;
        REG_SPINDOWN:    cfg_d.spindown_ms    = cfg_data_i;
        REG_INCREMENT:   cfg_d.increment_ms   = cfg_data_i;
        REG_MAX_MOVE:    cfg_d.drive_limit_ms = cfg_data_i;
        default:         cfg_d = cfg_q; // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_on_ms      <= RST_PRECHARGE;
      cfg_q.main_settle_ms <= RST_MAIN_SETTLE;
      cfg_q.drive_ms       <= RST_PULSE;
      cfg_q.post_pause_ms  <= RST_POST_PAUSE;
      cfg_q.spindown_ms    <= RST_SPINDOWN;
      cfg_q.increment_ms   <= RST_INCREMENT;
      cfg_q.drive_limit_ms <= RST_MAX_MOVE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/rpms_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpms_seq_core
// Sequencer state and combinational event update; result of the item.
// ----------------------------------------------------------------------------
module rpms_seq_core
  import rpms_pkg::*;
#(
  parameter int ACTUATOR_COUNT = DefActuatorCount,
  parameter int TIME_BITS      = DefTimeBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      proc_en_i,
  input  rpms_in_t  item_i,
  input  rpms_cfg_t cfg_i,
  output rpms_out_t res_o
);

  localparam int WideW = (TIME_BITS > CfgW) ? TIME_BITS : CfgW;
  localparam logic [TIME_BITS-1:0] TMax = '1;
  localparam logic [TIME_BITS-1:0] TOne = TIME_BITS'(1);

  // register value clamped to the counter range
  function automatic logic [TIME_BITS-1:0] fit_time(input logic [CfgW-1:0] v);
    logic [WideW-1:0] w;
    begin
      w = WideW'(v);
      if (w > WideW'(TMax)) fit_time = TMax;
      else                  fit_time = w[TIME_BITS-1:0];
    end
  endfunction

  logic [PhaseW-1:0]    ph_q, ph_d;
  logic                 busy_q, busy_d;
  logic                 act_q, act_d;
  logic                 dir_q, dir_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0] el_q, el_d;

  logic [TIME_BITS-1:0] t_pre, t_main, t_pulse, t_pause, t_spin, t_inc, t_max;
  logic [TIME_BITS:0]   ext_sum;
  logic [TIME_BITS-1:0] ext_cand, ext_lim, el_inc;
  logic                 idx_ok;
  logic [WideW-1:0]     rem_wide;

  assign t_pre   = fit_time(cfg_i.pre_on_ms);
  assign t_main  = fit_time(cfg_i.main_settle_ms);
  assign t_pulse = fit_time(cfg_i.drive_ms);
  assign t_pause = fit_time(cfg_i.post_pause_ms);
  assign t_spin  = fit_time(cfg_i.spindown_ms);
  assign t_inc   = fit_time(cfg_i.increment_ms);
  assign t_max   = fit_time(cfg_i.drive_limit_ms);

  assign ext_sum  = {1'b0, rem_q} + {1'b0, t_inc};
  assign ext_cand = ext_sum[TIME_BITS] ? TMax : ext_sum[TIME_BITS-1:0];
  assign ext_lim  = (t_max > el_q) ? (t_max - el_q) : '0;
  assign el_inc   = (el_q == TMax) ? TMax : (el_q + TOne);
  assign idx_ok   = (ACTUATOR_COUNT > 1) || !item_i.actuator_index;

  always_comb begin
    ph_d   = ph_q;
    busy_d = busy_q;
    act_d  = act_q;
    dir_d  = dir_q;
    rem_d  = rem_q;
    el_d   = el_q;
    if (proc_en_i) begin
      unique case (item_i.opcode)
        OP_TICK: begin
          if (busy_q) begin
            if (rem_q <= TOne) begin
              unique case (ph_q)
                PH_PRE: begin
                  ph_d  = PH_MAIN;
                  rem_d = t_main;
                end
                PH_MAIN: begin
                  ph_d  = PH_PULSE;
                  rem_d = t_pulse;
                  el_d  = '0;
                end
                PH_PULSE: begin
                  ph_d  = PH_PAUSE;
                  rem_d = t_pause;
                end
                PH_PAUSE: begin
                  ph_d  = PH_SPIN;
                  rem_d = t_spin;
                end
                PH_SPIN: begin
                  ph_d  = PH_PREOFF;
                  rem_d = '0;
                end
                default: begin
                  // pre off done, or a stray code: sequence over
                  ph_d   = PH_IDLE;
                  busy_d = 1'b0;
                  rem_d  = '0;
                end
              endcase
            end else begin
              rem_d = rem_q - TOne;
              if (ph_q == PH_PULSE) el_d = el_inc;
            end
          end
        end
        OP_START: begin
          if (!busy_q && idx_ok) begin
            busy_d = 1'b1;
            act_d  = item_i.actuator_index;
            dir_d  = item_i.direction;
            el_d   = '0;
            ph_d   = PH_PRE;
            rem_d  = t_pre;
          end
        end
        OP_STOP: begin
          if (ph_q == PH_PULSE) begin
            ph_d  = PH_PAUSE;
            rem_d = t_pause;
          end
        end
        OP_EXTEND: begin
          if (ph_q == PH_PULSE) rem_d = (ext_cand > ext_lim) ? ext_lim : ext_cand;
        end
        OP_REDUCE: begin
          if (ph_q == PH_PULSE) begin
            if (rem_q <= t_inc) begin
              ph_d  = PH_PAUSE;
              rem_d = t_pause;
            end else begin
              rem_d = rem_q - t_inc;
            end
          end
        end
        default: ; // unknown event: state kept
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      busy_q <= 1'b0;
      act_q  <= 1'b0;
      dir_q  <= 1'b0;
      rem_q  <= '0;
      el_q   <= '0;
    end else begin
      ph_q   <= ph_d;
      busy_q <= busy_d;
      act_q  <= act_d;
      dir_q  <= dir_d;
      rem_q  <= rem_d;
      el_q   <= el_d;
    end
  end

  // result reflects the state after this item
  assign rem_wide = WideW'(rem_d);

  always_comb begin
    res_o.phase            = ph_d;
    res_o.busy_res         = busy_d;
    res_o.pre_relay_on     = (ph_d >= PH_PRE) && (ph_d <= PH_SPIN);
    res_o.main_relay_on    = (ph_d >= PH_MAIN) && (ph_d <= PH_PAUSE);
    res_o.actuator_on      = (ph_d == PH_PULSE);
    res_o.active_actuator  = act_d;
    res_o.active_direction = dir_d;
    res_o.remaining_ms     = (ph_d == PH_PULSE) ? rem_wide[CfgW-1:0] : '0;
  end

`ifndef SYNTH
  a_busy_when_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PH_IDLE) |-> busy_q)
    else $error("phase active without busy");

  a_idle_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (ph_q == PH_IDLE) && (rem_q == '0))
    else $error("not busy but phase or count left set");

  a_start_enters_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en_i && (item_i.opcode == OP_START) && !busy_q && idx_ok)
    |=> (ph_q == PH_PRE) && busy_q)
    else $error("accepted start did not enter precharge");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!proc_en_i) |=> $stable(ph_q) && $stable(rem_q) && $stable(el_q))
    else $error("state moved without an item");
`endif

endmodule

### hdl/relay_power_move_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_power_move_sequencer
// Timed buck supply and actuator relay sequencer driven by event items.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_ready_o    | in_item_i   (rpms_in_t)
//  out     | out_valid_o / out_ready_i  | out_item_o  (rpms_out_t)
//  cfg     | cfg_we_i (no stall)        | cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled; each item gives exactly one result.
//  An accepted item goes into the input register, then through the event
//  update into the result register, where its result is shown.
//  The state update is one compare/add stage between those two registers.
//  A stalled output holds its result; the input register still takes an
//  item, and in_ready_o drops only when both registers are full.
//  Reset clears phase, busy, latches and counters; registers take defaults.
// ----------------------------------------------------------------------------
module relay_power_move_sequencer
  import rpms_pkg::*;
#(
  parameter int ACTUATOR_COUNT = DefActuatorCount,
  parameter int TIME_BITS      = DefTimeBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // event items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpms_in_t           in_item_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpms_out_t          out_item_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  rpms_cfg_t cfg;
  rpms_out_t res;

  logic      s1_valid_q, s1_valid_d;
  rpms_in_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  rpms_out_t out_item_q;

  logic in_acc;
  logic out_free;
  logic proc_en;

  // result register is free if empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  // an item in the input register is processed when the result can land
  assign proc_en    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  rpms_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rpms_seq_core #(
    .ACTUATOR_COUNT (ACTUATOR_COUNT),
    .TIME_BITS      (TIME_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_en_i (proc_en),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // valid flags
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)       s1_valid_d = 1'b1;
    else if (proc_en) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (proc_en)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc)  s1_item_q  <= in_item_i;
    if (proc_en) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### dv/tb_relay_power_move_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relay_power_move_sequencer
// Self-checking bench for the relay power move sequencer. It covers a
// directed opening, then timing sets with state-aware random events under
// varied back-pressure, and compares every report against a local predictor.
// ----------------------------------------------------------------------------
module tb_relay_power_move_sequencer;
  import rpms_pkg::*;

  // Opcodes the block does not decode; it should report the state unchanged
  localparam logic [OpW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;

  localparam int NumSegments = 8;
  localparam int SegmentItems = 150;

  // --------------------------------------------------------------------------
  // Predictor and report store. Each accepted event updates the model state
  // and queues the one report it must produce; reports leave in order.
  // --------------------------------------------------------------------------
  class relay_sequence_scoreboard;
    logic [CfgW-1:0]   setting [NumCfg];
    logic [PhaseW-1:0] phase;
    bit                busy;
    bit                act_latch;
    bit                dir_latch;
    logic [CfgW-1:0]   ticks_left;
    logic [CfgW-1:0]   pulse_ticks;
    rpms_out_t         expected_reports [$];
    int mismatches;
    int reports_checked;
    int moves_started;
    int pulses_cut;
    int extends_taken;

    function new();
      setting[REG_PRECHARGE]   = RST_PRECHARGE;
      setting[REG_MAIN_SETTLE] = RST_MAIN_SETTLE;
      setting[REG_PULSE]       = RST_PULSE;
      setting[REG_POST_PAUSE]  = RST_POST_PAUSE;
      setting[REG_SPINDOWN]    = RST_SPINDOWN;
      setting[REG_INCREMENT]   = RST_INCREMENT;
      setting[REG_MAX_MOVE]    = RST_MAX_MOVE;
      phase       = PH_IDLE;
      busy        = 1'b0;
      act_latch   = 1'b0;
      dir_latch   = 1'b0;
      ticks_left  = '0;
      pulse_ticks = '0;
    endfunction

    // Sums saturate at the counter width
    function logic [CfgW-1:0] clip(logic [CfgW:0] v);
      return v[CfgW] ? {CfgW{1'b1}} : v[CfgW-1:0];
    endfunction

    function void enter_phase(logic [PhaseW-1:0] ph, logic [CfgW-1:0] ticks);
      phase      = ph;
      ticks_left = ticks;
    endfunction

    function void finish_pulse();
      enter_phase(PH_PAUSE, setting[REG_POST_PAUSE]);
    endfunction

    function void next_phase();
      case (phase)
        PH_PRE:   enter_phase(PH_MAIN, setting[REG_MAIN_SETTLE]);
        PH_MAIN: begin
          enter_phase(PH_PULSE, setting[REG_PULSE]);
          pulse_ticks = '0;
        end
        PH_PULSE: finish_pulse();
        PH_PAUSE: enter_phase(PH_SPIN, setting[REG_SPINDOWN]);
        PH_SPIN:  enter_phase(PH_PREOFF, '0);
        default: begin
          busy       = 1'b0;
          phase      = PH_IDLE;
          ticks_left = '0;
        end
      endcase
    endfunction

    function void note_event(rpms_in_t ev);
      logic [CfgW-1:0] limit_ms;
      logic [CfgW-1:0] grown;
      rpms_out_t       rep;
      case (ev.opcode)
        OP_TICK: begin
          if (busy) begin
            if (ticks_left <= CfgW'(1)) begin
              next_phase();
            end else begin
              ticks_left = ticks_left - CfgW'(1);
              if (phase == PH_PULSE)
                pulse_ticks = clip({1'b0, pulse_ticks} + (CfgW+1)'(1));
            end
          end
        end
        OP_START: begin
          if (!busy && int'(ev.actuator_index) < DefActuatorCount) begin
            busy        = 1'b1;
            act_latch   = ev.actuator_index;
            dir_latch   = ev.direction;
            pulse_ticks = '0;
            enter_phase(PH_PRE, setting[REG_PRECHARGE]);
            moves_started++;
          end
        end
        OP_STOP: begin
          if (phase == PH_PULSE) begin
            finish_pulse();
            pulses_cut++;
          end
        end
        OP_EXTEND: begin
          if (phase == PH_PULSE) begin
            // headroom left under the move limit, none once it is used up
            limit_ms = (setting[REG_MAX_MOVE] > pulse_ticks) ?
                       setting[REG_MAX_MOVE] - pulse_ticks : '0;
            grown = clip({1'b0, ticks_left} + {1'b0, setting[REG_INCREMENT]});
            ticks_left = (grown > limit_ms) ? limit_ms : grown;
            extends_taken++;
          end
        end
        OP_REDUCE: begin
          if (phase == PH_PULSE) begin
            if (ticks_left <= setting[REG_INCREMENT]) begin
              finish_pulse();
              pulses_cut++;
            end else begin
              ticks_left = ticks_left - setting[REG_INCREMENT];
            end
          end
        end
        default: ;
      endcase
      rep.phase            = phase;
      rep.busy_res         = busy;
      rep.pre_relay_on     = (phase >= PH_PRE) && (phase <= PH_SPIN);
      rep.main_relay_on    = (phase >= PH_MAIN) && (phase <= PH_PAUSE);
      rep.actuator_on      = (phase == PH_PULSE);
      rep.active_actuator  = act_latch;
      rep.active_direction = dir_latch;
      rep.remaining_ms     = (phase == PH_PULSE) ? ticks_left : '0;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(rpms_out_t got);
      rpms_out_t want;
      if (expected_reports.size() == 0) begin
        $error("report with no event awaiting it (phase %0d)", got.phase);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      compare_field("phase", 32'(want.phase), 32'(got.phase));
      compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      compare_field("pre_relay_on", 32'(want.pre_relay_on), 32'(got.pre_relay_on));
      compare_field("main_relay_on", 32'(want.main_relay_on), 32'(got.main_relay_on));
      compare_field("actuator_on", 32'(want.actuator_on), 32'(got.actuator_on));
      compare_field("active_actuator", 32'(want.active_actuator),
                    32'(got.active_actuator));
      compare_field("active_direction", 32'(want.active_direction),
                    32'(got.active_direction));
      compare_field("remaining_ms", 32'(want.remaining_ms), 32'(got.remaining_ms));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its connections
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  rpms_in_t           in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rpms_out_t          out_item_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  relay_power_move_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  relay_sequence_scoreboard sb;

  // Back-pressure knobs, in percent of cycles; recv_hold forces a long stall
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold      = 0;
  int events_sent    = 0;
  int timing_sets    = 0;

  logic [CfgW-1:0] plan [NumCfg];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous ceiling: the slowest legal run is a small fraction of this
  initial begin
    #5_000_000;
    $display("** relay_power_move_sequencer: FAILED **");
    $finish;
  end

  // Receiver: random stalls, plus a counted hold-off when asked for.
  // During the hold the sender keeps going, so the two internal registers
  // fill and in_ready_o must drop.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Output monitor; values seen here are the ones before this edge's update
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) sb.check_report(out_item_o);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic rpms_in_t make_event(logic [OpW-1:0] op, logic idx, logic dir);
    rpms_in_t ev;
    ev.opcode         = op;
    ev.actuator_index = idx;
    ev.direction      = dir;
    return ev;
  endfunction

  // Presents one event and returns at the edge that takes it. The predictor
  // is updated here, so the next choice of event already sees the new state.
  task automatic offer_event(input rpms_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_event(ev);
    events_sent++;
  endtask

  // Stop offering and let every outstanding report come out, plus a margin
  // past the two-stage pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block empty
  task automatic load_settings();
    for (int i = 0; i < NumCfg; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= plan[i];
      @(posedge clk_i);
      sb.setting[i] = plan[i];
    end
    cfg_we_i <= 1'b0;
    timing_sets++;
  endtask

  // Mostly short phases so that whole sequences run many times over
  function automatic logic [CfgW-1:0] short_span();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return CfgW'(1);
    if (r < 8) return CfgW'($urandom_range(2, 6));
    return CfgW'($urandom_range(7, 40));
  endfunction

  task automatic choose_plan(input int seg);
    int r;
    if (seg == 1) begin
      // low end: everything zero, but a pulse longer than the move limit
      foreach (plan[i]) plan[i] = '0;
      plan[REG_PULSE] = CfgW'(5);
    end else if (seg == 3) begin
      plan[REG_PRECHARGE]   = CfgW'(2);
      plan[REG_MAIN_SETTLE] = CfgW'(1);
      plan[REG_PULSE]       = '1;
      plan[REG_POST_PAUSE]  = CfgW'(1);
      plan[REG_SPINDOWN]    = CfgW'(2);
      plan[REG_INCREMENT]   = '1;
      plan[REG_MAX_MOVE]    = '1;
    end else begin
      plan[REG_PRECHARGE]   = short_span();
      plan[REG_MAIN_SETTLE] = short_span();
      plan[REG_POST_PAUSE]  = short_span();
      plan[REG_SPINDOWN]    = short_span();
      plan[REG_PULSE] = ($urandom_range(9) == 0) ? '1 : CfgW'($urandom_range(30));
      r = $urandom_range(9);
      plan[REG_INCREMENT] = (r == 0) ? '1 : (r == 1) ? '0 : CfgW'($urandom_range(1, 8));
      r = $urandom_range(9);
      plan[REG_MAX_MOVE] = (r == 0) ? '1 : (r == 1) ? '0 : CfgW'($urandom_range(1, 50));
    end
  endtask

  // State-aware choice: starts when idle, ticks while sequencing, extends and
  // reduces during the pulse, with a share of arbitrary events throughout.
  // A very long pulse is cut short so that sequences keep completing.
  function automatic rpms_in_t pick_event();
    rpms_in_t ev;
    int r;
    ev.actuator_index = 1'($urandom_range(1));
    ev.direction      = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (!sb.busy) begin
      if (r < 65) ev.opcode = OP_START;
      else if (r < 80) ev.opcode = OP_TICK;
      else ev.opcode = OpW'($urandom_range(7));
    end else if (sb.phase != PH_PULSE) begin
      if (r < 80) ev.opcode = OP_TICK;
      else if (r < 88) ev.opcode = OP_START;
      else ev.opcode = OpW'($urandom_range(7));
    end else if (sb.ticks_left > CfgW'(1000) && r < 50) begin
      ev.opcode = (r < 30) ? OP_STOP : OP_REDUCE;
    end else begin
      if (r < 60) ev.opcode = OP_TICK;
      else if (r < 72) ev.opcode = OP_EXTEND;
      else if (r < 84) ev.opcode = OP_REDUCE;
      else if (r < 90) ev.opcode = OP_STOP;
      else ev.opcode = OpW'($urandom_range(7));
    end
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short timings, every opcode, ignored events while idle and in
    // precharge, extend within the move limit and reduce down to a stop
    plan[REG_PRECHARGE]   = CfgW'(1);
    plan[REG_MAIN_SETTLE] = '0;
    plan[REG_PULSE]       = CfgW'(8);
    plan[REG_POST_PAUSE]  = CfgW'(2);
    plan[REG_SPINDOWN]    = CfgW'(1);
    plan[REG_INCREMENT]   = CfgW'(3);
    plan[REG_MAX_MOVE]    = CfgW'(12);
    load_settings();
    offer_event(make_event(OP_TICK, 1'b0, 1'b0));   // idle tick
    offer_event(make_event(OP_STOP, 1'b1, 1'b1));   // pulse-only events, idle
    offer_event(make_event(OP_EXTEND, 1'b0, 1'b1));
    offer_event(make_event(OP_REDUCE, 1'b1, 1'b0));
    offer_event(make_event(OP_SPARE5, 1'b1, 1'b1));
    offer_event(make_event(OP_SPARE6, 1'b0, 1'b0));
    offer_event(make_event(OP_SPARE7, 1'b1, 1'b1));
    offer_event(make_event(OP_START, 1'b1, 1'b1));
    offer_event(make_event(OP_START, 1'b0, 1'b0));  // busy, ignored
    offer_event(make_event(OP_EXTEND, 1'b0, 1'b0)); // not in pulse yet
    offer_event(make_event(OP_TICK, 1'b0, 1'b0));
    offer_event(make_event(OP_TICK, 1'b0, 1'b0));   // zero settle, into pulse
    offer_event(make_event(OP_EXTEND, 1'b0, 1'b0));
    offer_event(make_event(OP_REDUCE, 1'b0, 1'b0));
    offer_event(make_event(OP_TICK, 1'b0, 1'b0));
    offer_event(make_event(OP_TICK, 1'b0, 1'b0));
    offer_event(make_event(OP_EXTEND, 1'b0, 1'b0)); // grows by the increment, still under the move limit
    offer_event(make_event(OP_REDUCE, 1'b0, 1'b0));
    offer_event(make_event(OP_REDUCE, 1'b0, 1'b0));
    offer_event(make_event(OP_REDUCE, 1'b0, 1'b0)); // count at increment: stops
    while (sb.busy) offer_event(make_event(OP_TICK, 1'b0, 1'b0));
    drain();

    // Directed: top of range, extend saturates, stop ends the pulse
    plan[REG_PRECHARGE]   = '0;
    plan[REG_MAIN_SETTLE] = '0;
    plan[REG_PULSE]       = '1;
    plan[REG_POST_PAUSE]  = '0;
    plan[REG_SPINDOWN]    = '0;
    plan[REG_INCREMENT]   = '1;
    plan[REG_MAX_MOVE]    = '1;
    load_settings();
    offer_event(make_event(OP_START, 1'b0, 1'b0));
    offer_event(make_event(OP_TICK, 1'b1, 1'b1));
    offer_event(make_event(OP_TICK, 1'b1, 1'b1));
    offer_event(make_event(OP_EXTEND, 1'b1, 1'b1));
    offer_event(make_event(OP_STOP, 1'b1, 1'b1));
    while (sb.busy) offer_event(make_event(OP_TICK, 1'b0, 1'b0));
    drain();

    // Random segments: each takes a fresh timing set and a pressure profile
    for (int seg = 0; seg < NumSegments; seg++) begin
      choose_plan(seg);
      load_settings();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (seg == 4) recv_hold = 120;   // long hold with the sender flat out
      for (int n = 0; n < SegmentItems; n++) begin
        if (seg == 5 && n == SegmentItems / 2) drain();   // sender waits for all
        offer_event(pick_event());
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d events across %0d timing sets; %0d reports checked.",
             events_sent, timing_sets, sb.reports_checked);
    $display("Moves started %0d, pulses cut short %0d, extends applied %0d.",
             sb.moves_started, sb.pulses_cut, sb.extends_taken);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("** relay_power_move_sequencer: PASSED **");
    end else begin
      $display("** relay_power_move_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
